/* rtl/astar_open_set_priority_queue_macros.svh */
// Assertion macros for the open-set queue datapath.
`ifndef ASTAR_OPEN_SET_PRIORITY_QUEUE_MACROS_SVH
`define ASTAR_OPEN_SET_PRIORITY_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AOSPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define AOSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define AOSPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AOSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/aospq_pkg.sv */
`default_nettype none
package aospq_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int FUNC_W     = 2;
    localparam int POS_W      = 8;
    localparam int IDX_W      = 16;
    localparam int COST_W     = 15;
    localparam int EST_W      = 8;
    localparam int STAT_W     = 2;
    localparam int CNT_OUT_W  = 9;
    localparam int DIST_W     = POS_W + 1;
    localparam int KEY_W      = COST_W + EST_W + DIST_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_UPDATE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y = 4'd1;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [IDX_W-1:0]  idx;
        logic [COST_W-1:0] cost;
        logic [EST_W-1:0]  est;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        RD_TOP,
        RD_MID,
        RD_PTR,
        RD_PTR_PREV,
        RD_PTR_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic              latch;
        t_rd_sel           rd_sel;
        logic              wr_en;
        logic              wr_new;
        logic              search_init;
        logic              bs_step;
        logic              ptr_zero;
        logic              ptr_cnt;
        logic              ptr_inc;
        logic              ptr_dec;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              cnt_clr;
        logic              pop_cap;
        logic              stat_set;
        logic [STAT_W-1:0] stat_val;
        logic              res_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  lo_lt_hi;
        logic  ptr_gt_lo;
        logic  ptr_lt_cnt;
        logic  idx_match;
        logic  out_free;
    } t_stat;

    function automatic logic [DIST_W-1:0] manhattan(
        input logic [POS_W-1:0] x,
        input logic [POS_W-1:0] y,
        input logic [POS_W-1:0] gx,
        input logic [POS_W-1:0] gy
    );
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
        dx = (x > gx) ? (x - gx) : (gx - x);
        dy = (y > gy) ? (y - gy) : (gy - y);
        return {1'b0, dx} + {1'b0, dy};
    endfunction

endpackage
`default_nettype wire

/* rtl/aospq_op_if.sv */
`default_nettype none
interface aospq_op_if;
    logic                           valid;
    logic                           ready;
    logic [aospq_pkg::FUNC_W-1:0]   func;
    logic [aospq_pkg::POS_W-1:0]    pos_x;
    logic [aospq_pkg::POS_W-1:0]    pos_y;
    logic [aospq_pkg::IDX_W-1:0]    cell_index;
    logic [aospq_pkg::COST_W-1:0]   total_cost;
    logic [aospq_pkg::EST_W-1:0]    goal_estimate;

    modport source (
        output valid, func, pos_x, pos_y, cell_index, total_cost, goal_estimate,
        input  ready
    );
    modport sink (
        input  valid, func, pos_x, pos_y, cell_index, total_cost, goal_estimate,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/aospq_res_if.sv */
`default_nettype none
interface aospq_res_if;
    logic                             valid;
    logic                             ready;
    logic [aospq_pkg::STAT_W-1:0]     status;
    logic [aospq_pkg::POS_W-1:0]      out_x;
    logic [aospq_pkg::POS_W-1:0]      out_y;
    logic [aospq_pkg::IDX_W-1:0]      out_index;
    logic [aospq_pkg::COST_W-1:0]     out_cost;
    logic [aospq_pkg::CNT_OUT_W-1:0]  entry_count;

    modport source (
        output valid, status, out_x, out_y, out_index, out_cost, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_x, out_y, out_index, out_cost, entry_count,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/aospq_cfg_if.sv */
`default_nettype none
interface aospq_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [aospq_pkg::CFG_IDX_W-1:0]   index;
    logic [aospq_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/aospq_ram.sv */
`default_nettype none
module aospq_ram #(
    parameter int WIDTH = aospq_pkg::ENTRY_W,
    parameter int DEPTH = aospq_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

/* rtl/aospq_ctrl.sv */
`default_nettype none
module aospq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output aospq_pkg::t_cmd  o_cmd,
    input  aospq_pkg::t_stat i_stat
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS,
        S_BS_CHK,
        S_BS_CMP,
        S_SH_CHK,
        S_SH_WR,
        S_POP,
        S_SCAN_CHK,
        S_SCAN_CMP,
        S_DEL_CHK,
        S_DEL_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    aospq_pkg::FUNC_INSERT: n_state = S_INS;
                    aospq_pkg::FUNC_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.stat_set = 1'b1;
                            o_cmd.stat_val = aospq_pkg::STAT_EMPTY;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.rd_sel = aospq_pkg::RD_TOP;
                            n_state      = S_POP;
                        end
                    end
                    aospq_pkg::FUNC_UPDATE: begin
                        o_cmd.ptr_zero = 1'b1;
                        n_state        = S_SCAN_CHK;
                    end
                    default: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_INS: begin
                if (i_stat.full) begin
                    o_cmd.stat_set = 1'b1;
                    o_cmd.stat_val = aospq_pkg::STAT_FULL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.search_init = 1'b1;
                    n_state           = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.rd_sel = aospq_pkg::RD_MID;
                    n_state      = S_BS_CMP;
                end else begin
                    o_cmd.ptr_cnt = 1'b1;
                    n_state       = S_SH_CHK;
                end
            end
            S_BS_CMP: begin
                o_cmd.bs_step = 1'b1;
                n_state       = S_BS_CHK;
            end
            S_SH_CHK: begin
                if (i_stat.ptr_gt_lo) begin
                    o_cmd.rd_sel = aospq_pkg::RD_PTR_PREV;
                    n_state      = S_SH_WR;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.ptr_dec = 1'b1;
                n_state       = S_SH_CHK;
            end
            S_POP: begin
                o_cmd.pop_cap = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                n_state       = S_DONE;
            end
            S_SCAN_CHK: begin
                if (i_stat.ptr_lt_cnt) begin
                    o_cmd.rd_sel = aospq_pkg::RD_PTR;
                    n_state      = S_SCAN_CMP;
                end else begin
                    n_state = S_INS;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.idx_match) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DEL_CHK;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_SCAN_CHK;
                end
            end
            S_DEL_CHK: begin
                if (i_stat.ptr_lt_cnt) begin
                    o_cmd.rd_sel = aospq_pkg::RD_PTR_NEXT;
                    n_state      = S_DEL_WR;
                end else begin
                    n_state = S_INS;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                n_state       = S_DEL_CHK;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* rtl/aospq_dp.sv */
`default_nettype none
`include "astar_open_set_priority_queue_macros.svh"
module aospq_dp #(
    parameter int DEPTH = aospq_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  aospq_pkg::t_cmd                  i_cmd,
    output aospq_pkg::t_stat                 o_stat,
    input  logic [aospq_pkg::FUNC_W-1:0]     i_func,
    input  logic [aospq_pkg::POS_W-1:0]      i_pos_x,
    input  logic [aospq_pkg::POS_W-1:0]      i_pos_y,
    input  logic [aospq_pkg::IDX_W-1:0]      i_cell_index,
    input  logic [aospq_pkg::COST_W-1:0]     i_total_cost,
    input  logic [aospq_pkg::EST_W-1:0]      i_goal_estimate,
    aospq_res_if.source                      o_res,
    aospq_cfg_if.sink                        i_cfg
);
    localparam int CW    = $clog2(DEPTH);
    localparam int EXT_W = (CW > aospq_pkg::CNT_OUT_W) ? CW : aospq_pkg::CNT_OUT_W;

    logic [aospq_pkg::POS_W-1:0]   r_goal_x;
    logic [aospq_pkg::POS_W-1:0]   r_goal_y;
    aospq_pkg::t_func              r_func;
    aospq_pkg::t_entry             r_new;
    logic [aospq_pkg::KEY_W-1:0]   r_key;
    logic [CW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hi;
    logic [CW-1:0]                 r_ptr;
    logic [CW-1:0]                 r_count;
    logic [aospq_pkg::STAT_W-1:0]  r_status;
    aospq_pkg::t_entry             r_pop;
    logic                          r_out_valid;
    logic [aospq_pkg::STAT_W-1:0]  r_out_status;
    aospq_pkg::t_entry             r_out_entry;
    logic [aospq_pkg::CNT_OUT_W-1:0] r_out_count;

    logic [CW:0]                   w_sum;
    logic [CW-1:0]                 w_mid;
    logic [CW-1:0]                 w_rd_addr;
    logic [CW-1:0]                 w_wr_addr;
    logic [aospq_pkg::ENTRY_W-1:0] w_rd_data;
    logic [aospq_pkg::ENTRY_W-1:0] w_wr_data;
    aospq_pkg::t_entry             w_rd_entry;
    logic [aospq_pkg::KEY_W-1:0]   w_old_key;
    logic                          w_full;
    logic [EXT_W-1:0]              w_cnt_ext;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CW:1];
    assign w_rd_entry = aospq_pkg::t_entry'(w_rd_data);
    assign w_old_key  = {w_rd_entry.cost, w_rd_entry.est,
                         aospq_pkg::manhattan(w_rd_entry.x, w_rd_entry.y, r_goal_x, r_goal_y)};
    assign w_full     = ({1'b0, r_count} + (CW+1)'(1)) >= (CW+1)'(DEPTH);
    assign w_wr_addr  = i_cmd.wr_new ? r_lo : r_ptr;
    assign w_wr_data  = i_cmd.wr_new ? r_new : w_rd_data;
    assign w_cnt_ext  = EXT_W'(r_count);

    always_comb begin
        case (i_cmd.rd_sel)
            aospq_pkg::RD_TOP:      w_rd_addr = r_count - CW'(1);
            aospq_pkg::RD_MID:      w_rd_addr = w_mid;
            aospq_pkg::RD_PTR_PREV: w_rd_addr = r_ptr - CW'(1);
            aospq_pkg::RD_PTR_NEXT: w_rd_addr = r_ptr + CW'(1);
            default:                w_rd_addr = r_ptr;
        endcase
    end

    aospq_ram #(
        .WIDTH (aospq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    aospq_pkg::CFG_GOAL_X: r_goal_x <= i_cfg.data;
                    aospq_pkg::CFG_GOAL_Y: r_goal_y <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= aospq_pkg::t_func'(i_func);
            r_new    <= {i_pos_x, i_pos_y, i_cell_index, i_total_cost, i_goal_estimate};
            r_key    <= {i_total_cost, i_goal_estimate,
                         aospq_pkg::manhattan(i_pos_x, i_pos_y, r_goal_x, r_goal_y)};
            r_status <= aospq_pkg::STAT_OK;
            r_pop    <= '0;
        end
        if (i_cmd.stat_set) begin
            r_status <= i_cmd.stat_val;
        end
        if (i_cmd.pop_cap) begin
            r_pop <= w_rd_entry;
        end
        if (i_cmd.search_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.bs_step) begin
            if (r_key > w_old_key) begin
                r_hi <= w_mid;
            end else if (r_key < w_old_key) begin
                r_lo <= (r_lo == w_mid) ? (r_lo + CW'(1)) : w_mid;
            end else begin
                r_lo <= w_mid;
                r_hi <= w_mid;
            end
        end
        if (i_cmd.ptr_zero) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_cnt) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - CW'(1);
        end
        if (i_cmd.res_load) begin
            r_out_status <= r_status;
            r_out_entry  <= r_pop;
            r_out_count  <= w_cnt_ext[aospq_pkg::CNT_OUT_W-1:0];
        end
    end

    assign o_stat.func       = r_func;
    assign o_stat.full       = w_full;
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.lo_lt_hi   = (r_lo < r_hi);
    assign o_stat.ptr_gt_lo  = (r_ptr > r_lo);
    assign o_stat.ptr_lt_cnt = (r_ptr < r_count);
    assign o_stat.idx_match  = (w_rd_entry.idx == r_new.idx);
    assign o_stat.out_free   = !r_out_valid || o_res.ready;

    assign i_cfg.ready       = i_rst_n;
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.out_x       = r_out_entry.x;
    assign o_res.out_y       = r_out_entry.y;
    assign o_res.out_index   = r_out_entry.idx;
    assign o_res.out_cost    = r_out_entry.cost;
    assign o_res.entry_count = r_out_count;

    `AOSPQ_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_cmd.cnt_dec, r_count != '0)
    `AOSPQ_ASSERT_IMP(a_add_has_room, i_clk, i_rst_n, i_cmd.cnt_inc, !w_full)
    `AOSPQ_ASSERT_IMP(a_wr_in_range, i_clk, i_rst_n, i_cmd.wr_en, w_wr_addr <= r_count)
    `AOSPQ_ASSERT_NEXT(a_search_ordered, i_clk, i_rst_n, i_cmd.bs_step, r_lo <= r_hi)
endmodule
`default_nettype wire

/* rtl/astar_open_set_priority_queue.sv */
`default_nettype none
// Sorted open set for grid A* search, kept in one RAM of DEPTH entries (one read
// and one write port) with the best entry (lowest total cost, then estimate, then
// Manhattan distance to the goal) at the highest occupied slot. One word in gives
// one word out. Insert runs a binary search of about log2 of the count steps, then
// moves the entries from the landing slot up by one slot each. Update scans up to
// the match, closes the gap behind it, then inserts. The RAM does one read and one
// write per cycle and its read is registered. The user must write the goal
// registers only while the queue is idle; the block itself does not enforce this.
// Writes to other indexes are ignored.
module astar_open_set_priority_queue #(
    parameter int DEPTH = aospq_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aospq_op_if.sink     i_op,
    aospq_res_if.source  o_res,
    aospq_cfg_if.sink    i_cfg
);
    aospq_pkg::t_cmd  w_cmd;
    aospq_pkg::t_stat w_stat;

    aospq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_op.valid),
        .o_in_ready (i_op.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    aospq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_func          (i_op.func),
        .i_pos_x         (i_op.pos_x),
        .i_pos_y         (i_op.pos_y),
        .i_cell_index    (i_op.cell_index),
        .i_total_cost    (i_op.total_cost),
        .i_goal_estimate (i_op.goal_estimate),
        .o_res           (o_res),
        .i_cfg           (i_cfg)
    );
endmodule
`default_nettype wire

/* test/astar_open_set_priority_queue_tb.sv */
`timescale 1ns / 100ps

module astar_open_set_priority_queue_tb;
    import aospq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 10_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned ID_POOL      = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

    typedef struct {
        t_func             func;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [IDX_W-1:0]  idx;
        logic [COST_W-1:0] cost;
        logic [EST_W-1:0]  est;
    } op_word_t;

    typedef struct {
        logic [STAT_W-1:0]    status;
        logic [POS_W-1:0]     x;
        logic [POS_W-1:0]     y;
        logic [IDX_W-1:0]     idx;
        logic [COST_W-1:0]    cost;
        logic [CNT_OUT_W-1:0] count;
    } res_word_t;

    class open_set_scoreboard;
        t_entry           slots[DEPTH_DEF];
        int unsigned      held;
        logic [POS_W-1:0] goal_x;
        logic [POS_W-1:0] goal_y;
        res_word_t        due_results[$];
        int unsigned      fails;

        function new();
            held   = 0;
            goal_x = '0;
            goal_y = '0;
            fails  = 0;
        endfunction

        function void set_goal(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_GOAL_X) begin
                goal_x = data;
            end else if (index == CFG_GOAL_Y) begin
                goal_y = data;
            end
        endfunction

        function int unsigned goal_distance(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
            int unsigned dx;
            int unsigned dy;
            dx = (x > goal_x) ? 32'(x - goal_x) : 32'(goal_x - x);
            dy = (y > goal_y) ? 32'(y - goal_y) : 32'(goal_y - y);
            return dx + dy;
        endfunction

        // +1: a has the larger key and sits at a lower slot
        function int rank_order(t_entry a, t_entry b);
            int unsigned da;
            int unsigned db;
            da = goal_distance(a.x, a.y);
            db = goal_distance(b.x, b.y);
            if (a.cost != b.cost) return (a.cost > b.cost) ? 1 : -1;
            if (a.est != b.est) return (a.est > b.est) ? 1 : -1;
            if (da != db) return (da > db) ? 1 : -1;
            return 0;
        endfunction

        // returns 1 when refused for lack of room
        function logic sorted_place(t_entry e);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            int unsigned i;
            int          c;
            if (held + 1 >= DEPTH_DEF) return 1'b1;
            lo = 0;
            hi = held;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                c = rank_order(e, slots[mid]);
                if (c > 0) begin
                    hi = mid;
                end else if (c < 0) begin
                    if (lo == mid) lo++;
                    else lo = mid;
                end else begin
                    lo = mid;
                    hi = mid;
                end
            end
            i = held;
            while (i > lo) begin
                slots[i] = slots[i-1];
                i--;
            end
            slots[lo] = e;
            held++;
            return 1'b0;
        endfunction

        function void note_op(op_word_t w);
            res_word_t   r;
            t_entry      e;
            int unsigned i;
            r = '{default: '0};
            e.x    = w.x;
            e.y    = w.y;
            e.idx  = w.idx;
            e.cost = w.cost;
            e.est  = w.est;
            r.status = STAT_OK;
            case (w.func)
                FUNC_INSERT: begin
                    if (sorted_place(e)) r.status = STAT_FULL;
                end
                FUNC_POP: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        held--;
                        r.x    = slots[held].x;
                        r.y    = slots[held].y;
                        r.idx  = slots[held].idx;
                        r.cost = slots[held].cost;
                    end
                end
                FUNC_UPDATE: begin
                    i = 0;
                    while (i < held && slots[i].idx != w.idx) i++;
                    if (i < held) begin
                        held--;
                        while (i < held) begin
                            slots[i] = slots[i+1];
                            i++;
                        end
                    end
                    if (sorted_place(e)) r.status = STAT_FULL;
                end
                default: begin
                    held = 0;
                end
            endcase
            r.count = CNT_OUT_W'(held);
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(res_word_t got);
            res_word_t want;
            if (due_results.size() == 0) begin
                $error("result word with nothing expected: status %0d, entry_count %0d",
                       got.status, got.count);
                fails++;
                return;
            end
            want = due_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_x", 32'(want.x), 32'(got.x));
            compare_field("out_y", 32'(want.y), 32'(got.y));
            compare_field("out_index", 32'(want.idx), 32'(got.idx));
            compare_field("out_cost", 32'(want.cost), 32'(got.cost));
            compare_field("entry_count", 32'(want.count), 32'(got.count));
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               calm = 1'b0;
    bit                 hold_req = 1'b0;
    int unsigned        hold_left = 0;
    int unsigned        cycle_count = 0;
    logic [IDX_W-1:0]   live_ids[$];
    open_set_scoreboard sb;

    aospq_op_if  op_bus();
    aospq_res_if res_bus();
    aospq_cfg_if cfg_bus();

    astar_open_set_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        res_word_t got;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                got.status = res_bus.status;
                got.x      = res_bus.out_x;
                got.y      = res_bus.out_y;
                got.idx    = res_bus.out_index;
                got.cost   = res_bus.out_cost;
                got.count  = res_bus.entry_count;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= calm || ($urandom_range(99) >= 38);
            end
        end
    end

    function automatic op_word_t word(t_func f, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [IDX_W-1:0] idx, logic [COST_W-1:0] cost,
                                      logic [EST_W-1:0] est);
        op_word_t w;
        w.func = f;
        w.x    = x;
        w.y    = y;
        w.idx  = idx;
        w.cost = cost;
        w.est  = est;
        return w;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // small ranges often, so that keys tie
    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return COST_W'($urandom_range(15));
            default: return COST_W'($urandom);
        endcase
    endfunction

    function automatic logic [EST_W-1:0] pick_est();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3, 4: return EST_W'($urandom_range(3));
            default: return EST_W'($urandom);
        endcase
    endfunction

    function automatic t_func mix_func();
        int unsigned r = $urandom_range(99);
        if (r < 40) return FUNC_INSERT;
        if (r < 68) return FUNC_POP;
        if (r < 96) return FUNC_UPDATE;
        return FUNC_CLEAR;
    endfunction

    function automatic op_word_t gen_op(t_func f);
        op_word_t w;
        bit       reuse;
        w = word(f, pick_pos(), pick_pos(), IDX_W'($urandom), pick_cost(), pick_est());
        reuse = (f == FUNC_UPDATE) ? ($urandom_range(3) != 0) : ($urandom_range(7) == 0);
        if (reuse && live_ids.size() != 0) w.idx = live_ids[$urandom_range(live_ids.size() - 1)];
        if (f == FUNC_INSERT || f == FUNC_UPDATE) begin
            live_ids.push_back(w.idx);
            if (live_ids.size() > ID_POOL) void'(live_ids.pop_front());
        end
        return w;
    endfunction

    task automatic send_op(op_word_t w);
        op_bus.valid         <= 1'b1;
        op_bus.func          <= w.func;
        op_bus.pos_x         <= w.x;
        op_bus.pos_y         <= w.y;
        op_bus.cell_index    <= w.idx;
        op_bus.total_cost    <= w.cost;
        op_bus.goal_estimate <= w.est;
        do @(posedge i_clk); while (op_bus.ready !== 1'b1);
        sb.note_op(w);
        if (!calm && $urandom_range(99) < 38) begin
            op_bus.valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain_ops();
        op_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_goal(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        sb.set_goal(index, data);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n              <= 1'b0;
        op_bus.valid         <= 1'b0;
        op_bus.func          <= FUNC_INSERT;
        op_bus.pos_x         <= '0;
        op_bus.pos_y         <= '0;
        op_bus.cell_index    <= '0;
        op_bus.total_cost    <= '0;
        op_bus.goal_estimate <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= CFG_GOAL_X;
        cfg_bus.data         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, goal at reset value
        send_op(word(FUNC_POP, 8'd0, 8'd0, 16'h0000, 15'd0, 8'd0));
        send_op(word(FUNC_CLEAR, 8'd0, 8'd0, 16'h0000, 15'd0, 8'd0));
        send_op(word(FUNC_UPDATE, 8'hFF, 8'hFF, 16'hFFFF, 15'h7FFF, 8'hFF));
        send_op(word(FUNC_INSERT, 8'd0, 8'd0, 16'h0000, 15'd0, 8'd0));
        send_op(word(FUNC_INSERT, 8'hFF, 8'hFF, 16'h1234, 15'd0, 8'd0));
        send_op(word(FUNC_INSERT, 8'd0, 8'd0, 16'h0007, 15'd0, 8'd0));
        send_op(word(FUNC_INSERT, 8'd3, 8'd4, 16'h00A5, 15'd5, 8'hFF));
        send_op(word(FUNC_INSERT, 8'd10, 8'd0, 16'h5A00, 15'd5, 8'd0));
        send_op(word(FUNC_INSERT, 8'd0, 8'd10, 16'h0F0F, 15'd5, 8'd0));
        send_op(word(FUNC_INSERT, 8'd128, 8'd127, 16'h8000, 15'h4000, 8'h80));
        send_op(word(FUNC_UPDATE, 8'd1, 8'd1, 16'h1234, 15'd1, 8'd0));
        send_op(word(FUNC_UPDATE, 8'd2, 8'd2, 16'hFFFF, 15'd2, 8'd0));
        send_op(word(FUNC_UPDATE, 8'd9, 8'd9, 16'h7777, 15'd3, 8'd3));
        repeat (6) send_op(word(FUNC_POP, 8'd0, 8'd0, 16'h0000, 15'd0, 8'd0));
        send_op(word(FUNC_INSERT, 8'd0, 8'hFF, 16'h0001, 15'h7FFF, 8'd0));
        send_op(word(FUNC_CLEAR, 8'd0, 8'd0, 16'h0000, 15'd0, 8'd0));
        send_op(word(FUNC_POP, 8'd0, 8'd0, 16'h0000, 15'd0, 8'd0));
        drain_ops();

        write_goal(CFG_GOAL_X, 8'hFF);
        write_goal(CFG_GOAL_Y, 8'hFF);
        write_goal(CFG_SPARE, CFG_DATA_W'($urandom));
        repeat (100) send_op(gen_op(mix_func()));
        calm = 1'b1;
        repeat (100) send_op(gen_op(mix_func()));
        calm = 1'b0;
        drain_ops();

        // fill to the top under a long result hold-off, then empty it out
        write_goal(CFG_GOAL_X, CFG_DATA_W'($urandom));
        write_goal(CFG_GOAL_Y, CFG_DATA_W'($urandom));
        send_op(gen_op(FUNC_CLEAR));
        hold_req = 1'b1;
        repeat (320) send_op(gen_op(($urandom_range(7) == 0) ? FUNC_UPDATE : FUNC_INSERT));
        repeat (270) send_op(gen_op(FUNC_POP));
        drain_ops();

        write_goal(CFG_GOAL_X, 8'h00);
        write_goal(CFG_GOAL_Y, 8'hFF);
        repeat (100) send_op(gen_op(mix_func()));
        drain_ops();
        repeat (100) send_op(gen_op(mix_func()));
        drain_ops();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/aospq_pkg.sv
rtl/aospq_op_if.sv
rtl/aospq_res_if.sv
rtl/aospq_cfg_if.sv
rtl/aospq_ram.sv
rtl/aospq_ctrl.sv
rtl/aospq_dp.sv
rtl/astar_open_set_priority_queue.sv
test/astar_open_set_priority_queue_tb.sv
